>>> hdl/itf_pkg.sv
package itf_pkg;

    // Bit positions inside the format flags word
    localparam int unsigned FLAG_LEFT    = 0;
    localparam int unsigned FLAG_ZEROPAD = 1;
    localparam int unsigned FLAG_PLUS    = 2;
    localparam int unsigned FLAG_SPACE   = 3;
    localparam int unsigned FLAG_HASH    = 4;
    localparam int unsigned FLAG_PREC    = 5;
    localparam int unsigned FLAG_UPPER   = 6;

    // Radix codes
    localparam logic [1:0] RADIX_BIN = 2'd0;
    localparam logic [1:0] RADIX_OCT = 2'd1;
    localparam logic [1:0] RADIX_DEC = 2'd2;
    localparam logic [1:0] RADIX_HEX = 2'd3;

    // ASCII characters used by the formatter
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_LX    = 8'h78;
    localparam logic [7:0] CH_UX    = 8'h58;
    localparam logic [7:0] CH_LB    = 8'h62;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_LA    = 8'h61;

    // Most text emitted for one number
    localparam logic [5:0] MAX_CHARS = 6'd63;

    // Reciprocal of ten for a 12-bit dividend: q = (x * RECIP10) >> 19
    localparam logic [15:0] RECIP10 = 16'd52429;

    // Sequencer states
    typedef enum logic [10:0] {
        ST_IDLE  = 11'b000_0000_0001,
        ST_DIV   = 11'b000_0000_0010,
        ST_PREC  = 11'b000_0000_0100,
        ST_ZPAD  = 11'b000_0000_1000,
        ST_HASH  = 11'b000_0001_0000,
        ST_PFX   = 11'b000_0010_0000,
        ST_HZERO = 11'b000_0100_0000,
        ST_SIGN  = 11'b000_1000_0000,
        ST_PLAN  = 11'b001_0000_0000,
        ST_ENEXT = 11'b010_0000_0000,
        ST_EREAD = 11'b100_0000_0000
    } itf_state_t;

endpackage

>>> hdl/integer_to_text_formatter_unit.sv
// Integer to text formatter.
// An input word carries a 64-bit magnitude, a sign mark, a radix code, a
// precision, a field width and format flags. It is taken on in_valid and
// in_ready; in_ready is high only while the block is idle, so one number is
// formatted at a time. The text leaves on out_valid and out_ready, one
// character per word, most significant character first, with is_last set on
// the final character. At most 63 characters are sent; an empty text sends
// no word at all.
// Digit generation takes one digit per step in binary, octal and hex. In
// decimal a shared divide-by-ten step handles one byte of the magnitude per
// cycle and passes over the whole magnitude for each digit. Precision zeros,
// padding zeros, the alternate-form prefix and the sign are then stored in
// turn, and a planning step sets up emission. Emission sends leading spaces,
// then the stored characters, read through the digit memory's registered
// read port, then trailing spaces, and then returns to idle.
// A receiver that holds out_ready low simply stalls the sequencer; no word
// is lost or repeated.
// Reset clears the sequencer and the output valid flag; the digit memory is
// not cleared, since each number writes every entry it later reads.
module integer_to_text_formatter_unit
    import itf_pkg::*;
#(
    parameter int DIGIT_BUFFER_DEPTH = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [63:0] magnitude,
    input  logic        is_negative,
    input  logic [1:0]  radix_code,
    input  logic [5:0]  min_digits,
    input  logic [5:0]  field_width,
    input  logic [6:0]  format_flags,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  character,
    output logic        is_last
);

    localparam int CW = $clog2(DIGIT_BUFFER_DEPTH + 1);
    localparam int AW = $clog2(DIGIT_BUFFER_DEPTH);
    localparam logic [CW-1:0] DEPTH_C = CW'(DIGIT_BUFFER_DEPTH);

    itf_state_t     state_reg, state_next;
    logic [63:0]    val_reg, val_next;
    logic [3:0]     rem_reg, rem_next;
    logic [2:0]     step_reg, step_next;
    logic [CW-1:0]  cnt_reg, cnt_next;
    logic [5:0]     prec_reg, prec_next;
    logic [5:0]     w_reg, w_next;
    logic [1:0]     radix_reg, radix_next;
    logic           neg_reg, neg_next;
    logic           left_reg, left_next;
    logic           zp_reg, zp_next;
    logic           plus_reg, plus_next;
    logic           space_reg, space_next;
    logic           hash_reg, hash_next;
    logic           precg_reg, precg_next;
    logic           upper_reg, upper_next;
    logic [5:0]     lpad_reg, lpad_next;
    logic [5:0]     rpad_reg, rpad_next;
    logic [CW-1:0]  idx_reg, idx_next;
    logic [5:0]     tot_reg, tot_next;
    logic           ovalid_reg, ovalid_next;
    logic [7:0]     ochar_reg, ochar_next;
    logic           olast_reg, olast_next;

    logic           push_en;
    logic [7:0]     push_ch;
    logic           ram_re;
    logic [AW-1:0]  ram_raddr;
    logic [7:0]     ram_rdata;
    logic           slot_free;
    logic           not_full;
    logic [CW-1:0]  cnt_inc;
    logic [CW-1:0]  cnt_dec;
    logic [CW-1:0]  idx_dec;

    // Divide-by-ten step and digit character
    logic [11:0]    div_x;
    logic [27:0]    div_prod;
    logic [7:0]     div_q;
    logic [11:0]    div_r;
    logic [3:0]     dig;
    logic [63:0]    val_shift;
    logic [7:0]     dig_ch;

    // Emission plan
    logic [5:0]     plan_pad;
    logic [7:0]     plan_sum;

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = ovalid_reg;
    assign character = ochar_reg;
    assign is_last   = olast_reg;

    assign slot_free = !ovalid_reg || out_ready;
    assign not_full  = (cnt_reg < DEPTH_C);
    assign cnt_inc   = cnt_reg + 1'b1;
    assign cnt_dec   = cnt_reg - 1'b1;
    assign idx_dec   = idx_reg - 1'b1;

    // One byte of long division by ten, remainder carried between steps
    assign div_x    = {rem_reg, val_reg[63:56]};
    assign div_prod = 28'(div_x) * 28'(RECIP10);
    assign div_q    = div_prod[26:19];
    assign div_r    = div_x - (12'(div_q) * 12'd10);

    // Digit value and remaining value for each radix; decimal uses the divide step
    always_comb
    begin
        case (radix_reg)
            RADIX_BIN:
            begin
                dig       = {3'b000, val_reg[0]};
                val_shift = val_reg >> 1;
            end
            RADIX_OCT:
            begin
                dig       = {1'b0, val_reg[2:0]};
                val_shift = val_reg >> 3;
            end
            RADIX_HEX:
            begin
                dig       = val_reg[3:0];
                val_shift = val_reg >> 4;
            end
            default:
            begin
                dig       = div_r[3:0];
                val_shift = {val_reg[55:0], div_q};
            end
        endcase
    end

    // Digit to ASCII
    always_comb
    begin
        if (dig < 4'd10)
        begin
            dig_ch = CH_ZERO + 8'(dig);
        end
        else
        begin
            dig_ch = (upper_reg ? CH_UA : CH_LA) + 8'(dig) - 8'd10;
        end
    end

    // Padding that goes with the final character count
    always_comb
    begin
        if (8'(cnt_reg) < 8'(w_reg))
        begin
            plan_pad = 6'(8'(w_reg) - 8'(cnt_reg));
        end
        else
        begin
            plan_pad = 6'd0;
        end
        plan_sum = 8'(cnt_reg) + 8'(plan_pad);
        if (!left_reg && zp_reg)
        begin
            plan_sum = 8'(cnt_reg);
        end
    end

    // Sequencer
    always_comb
    begin
        state_next  = state_reg;
        val_next    = val_reg;
        rem_next    = rem_reg;
        step_next   = step_reg;
        cnt_next    = cnt_reg;
        prec_next   = prec_reg;
        w_next      = w_reg;
        radix_next  = radix_reg;
        neg_next    = neg_reg;
        left_next   = left_reg;
        zp_next     = zp_reg;
        plus_next   = plus_reg;
        space_next  = space_reg;
        hash_next   = hash_reg;
        precg_next  = precg_reg;
        upper_next  = upper_reg;
        lpad_next   = lpad_reg;
        rpad_next   = rpad_reg;
        idx_next    = idx_reg;
        tot_next    = tot_reg;
        ovalid_next = ovalid_reg && !out_ready;
        ochar_next  = ochar_reg;
        olast_next  = olast_reg;
        push_en     = 1'b0;
        push_ch     = CH_ZERO;
        ram_re      = 1'b0;
        ram_raddr   = idx_dec[AW-1:0];

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    val_next   = magnitude;
                    rem_next   = 4'd0;
                    step_next  = 3'd0;
                    cnt_next   = '0;
                    prec_next  = min_digits;
                    radix_next = radix_code;
                    neg_next   = is_negative;
                    left_next  = format_flags[FLAG_LEFT];
                    zp_next    = format_flags[FLAG_ZEROPAD];
                    plus_next  = format_flags[FLAG_PLUS];
                    space_next = format_flags[FLAG_SPACE];
                    hash_next  = format_flags[FLAG_HASH] && (magnitude != 64'd0);
                    precg_next = format_flags[FLAG_PREC];
                    upper_next = format_flags[FLAG_UPPER];
                    // One column is kept for the sign when zero padding
                    if ((field_width != 6'd0) && format_flags[FLAG_ZEROPAD] &&
                        (is_negative || format_flags[FLAG_PLUS] ||
                         format_flags[FLAG_SPACE]))
                    begin
                        w_next = field_width - 6'd1;
                    end
                    else
                    begin
                        w_next = field_width;
                    end
                    if (format_flags[FLAG_PREC] && (magnitude == 64'd0))
                    begin
                        state_next = ST_PREC;
                    end
                    else
                    begin
                        state_next = ST_DIV;
                    end
                end
            end

            ST_DIV:
            begin
                val_next = val_shift;
                if ((radix_reg == RADIX_DEC) && (step_reg != 3'd7))
                begin
                    rem_next  = div_r[3:0];
                    step_next = step_reg + 3'd1;
                end
                else
                begin
                    rem_next  = 4'd0;
                    step_next = 3'd0;
                    push_en   = 1'b1;
                    push_ch   = dig_ch;
                    if ((val_shift == 64'd0) || (cnt_inc == DEPTH_C))
                    begin
                        state_next = ST_PREC;
                    end
                end
            end

            ST_PREC:
            begin
                if ((8'(cnt_reg) < 8'(prec_reg)) && not_full)
                begin
                    push_en = 1'b1;
                end
                else
                begin
                    state_next = ST_ZPAD;
                end
            end

            ST_ZPAD:
            begin
                if (zp_reg && (8'(cnt_reg) < 8'(w_reg)) && not_full)
                begin
                    push_en = 1'b1;
                end
                else
                begin
                    state_next = hash_reg ? ST_HASH : ST_SIGN;
                end
            end

            ST_HASH:
            begin
                // Make room for the prefix when the text is already at size
                if (!precg_reg && (cnt_reg != '0) &&
                    ((8'(cnt_reg) == 8'(prec_reg)) || (8'(cnt_reg) == 8'(w_reg))))
                begin
                    if ((radix_reg == RADIX_HEX) && (cnt_dec != '0))
                    begin
                        cnt_next = cnt_reg - CW'(2);
                    end
                    else
                    begin
                        cnt_next = cnt_dec;
                    end
                end
                state_next = ST_PFX;
            end

            ST_PFX:
            begin
                if ((radix_reg == RADIX_HEX) && not_full)
                begin
                    push_en    = 1'b1;
                    push_ch    = upper_reg ? CH_UX : CH_LX;
                    space_next = 1'b0;
                end
                else if ((radix_reg == RADIX_BIN) && not_full)
                begin
                    push_en = 1'b1;
                    push_ch = CH_LB;
                end
                state_next = ST_HZERO;
            end

            ST_HZERO:
            begin
                push_en    = 1'b1;
                state_next = ST_SIGN;
            end

            ST_SIGN:
            begin
                if (neg_reg)
                begin
                    push_en = 1'b1;
                    push_ch = CH_MINUS;
                end
                else if (plus_reg)
                begin
                    push_en = 1'b1;
                    push_ch = CH_PLUS;
                end
                else if (space_reg)
                begin
                    push_en = 1'b1;
                    push_ch = CH_SPACE;
                end
                state_next = ST_PLAN;
            end

            ST_PLAN:
            begin
                lpad_next = (!left_reg && !zp_reg) ? plan_pad : 6'd0;
                rpad_next = left_reg ? plan_pad : 6'd0;
                idx_next  = cnt_reg;
                tot_next  = (plan_sum > 8'(MAX_CHARS)) ? MAX_CHARS : plan_sum[5:0];
                state_next = ((plan_sum == 8'd0)) ? ST_IDLE : ST_ENEXT;
            end

            ST_ENEXT:
            begin
                if (tot_reg == 6'd0)
                begin
                    state_next = ST_IDLE;
                end
                else if (lpad_reg != 6'd0)
                begin
                    if (slot_free)
                    begin
                        ovalid_next = 1'b1;
                        ochar_next  = CH_SPACE;
                        olast_next  = (tot_reg == 6'd1);
                        tot_next    = tot_reg - 6'd1;
                        lpad_next   = lpad_reg - 6'd1;
                    end
                end
                else if (idx_reg != '0)
                begin
                    ram_re     = 1'b1;
                    idx_next   = idx_dec;
                    state_next = ST_EREAD;
                end
                else if (slot_free)
                begin
                    ovalid_next = 1'b1;
                    ochar_next  = CH_SPACE;
                    olast_next  = (tot_reg == 6'd1);
                    tot_next    = tot_reg - 6'd1;
                    rpad_next   = rpad_reg - 6'd1;
                end
            end

            ST_EREAD:
            begin
                if (slot_free)
                begin
                    ovalid_next = 1'b1;
                    ochar_next  = ram_rdata;
                    olast_next  = (tot_reg == 6'd1);
                    tot_next    = tot_reg - 6'd1;
                    state_next  = ST_ENEXT;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // Store pushes saturate at the buffer size
        if (push_en && not_full)
        begin
            cnt_next = cnt_inc;
        end
    end

    // Digit store
    itf_ram #(
        .WIDTH (8),
        .DEPTH (DIGIT_BUFFER_DEPTH)
    ) u_digits (
        .clk   (clk),
        .we    (push_en && not_full),
        .waddr (cnt_reg[AW-1:0]),
        .wdata (push_ch),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            ovalid_reg <= 1'b0;
            cnt_reg    <= '0;
            step_reg   <= 3'd0;
            tot_reg    <= 6'd0;
        end
        else
        begin
            state_reg  <= state_next;
            ovalid_reg <= ovalid_next;
            cnt_reg    <= cnt_next;
            step_reg   <= step_next;
            tot_reg    <= tot_next;
        end
    end

    // Working registers
    always_ff @(posedge clk)
    begin
        val_reg   <= val_next;
        rem_reg   <= rem_next;
        prec_reg  <= prec_next;
        w_reg     <= w_next;
        radix_reg <= radix_next;
        neg_reg   <= neg_next;
        left_reg  <= left_next;
        zp_reg    <= zp_next;
        plus_reg  <= plus_next;
        space_reg <= space_next;
        hash_reg  <= hash_next;
        precg_reg <= precg_next;
        upper_reg <= upper_next;
        lpad_reg  <= lpad_next;
        rpad_reg  <= rpad_next;
        idx_reg   <= idx_next;
        ochar_reg <= ochar_next;
        olast_reg <= olast_next;
    end

    // The digit count never passes the buffer size
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= DEPTH_C)
        else $error("digit count beyond buffer size");

    // The sequencer holds exactly one state
    a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg))
        else $error("sequencer state not one-hot");

    // A new character is only loaded by the emission states
    a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> ($past(state_reg) == ST_ENEXT || $past(state_reg) == ST_EREAD))
        else $error("character loaded outside emission");

    // The division step counter only runs during digit generation
    a_step_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (step_reg != 3'd0) |-> (state_reg == ST_DIV))
        else $error("division step active outside digit generation");

endmodule

>>> hdl/itf_ram.sv
module itf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Single write port, registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
